// ----- hw/rtl/monitor_jitter_buffer_mixer_macros.svh -----
// ----------------------------------------------------------------------------
// Monitor jitter buffer mixer: assertion macros
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef MONITOR_JITTER_BUFFER_MIXER_MACROS_SVH
`define MONITOR_JITTER_BUFFER_MIXER_MACROS_SVH

// Same-cycle implication
`define MJB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MJB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mjb_pkg.sv -----
// ----------------------------------------------------------------------------
// mjb_pkg
// Shared constants, request/result types and arithmetic helpers.
// ----------------------------------------------------------------------------
package mjb_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 16384;
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int PW         = $clog2(2 * RING_DEPTH);
  localparam int HALF       = RING_DEPTH / 2;
  localparam int CW         = $clog2(HALF + 1);
  localparam int MW         = (CW > 15) ? CW : 15;

  localparam logic [PW:0]   SPAN_W  = (PW + 1)'(2 * RING_DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(RING_DEPTH);

  // Queue depths (powers of two)
  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);
  localparam int QCW      = $clog2(QDEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQAW     = $clog2(OQ_DEPTH);
  localparam int OQCW     = $clog2(OQ_DEPTH + 1);

  // Gain unity in Q2.14
  localparam logic [14:0] GAIN_UNITY = 15'd16384;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_MONITOR_GAIN = 3'd0;
  localparam logic [2:0] CFG_BOARD_GAIN   = 3'd1;
  localparam logic [2:0] CFG_DUCK_GAIN    = 3'd2;
  localparam logic [2:0] CFG_DUCK_EN      = 3'd3;
  localparam logic [2:0] CFG_LOOPBACK_EN  = 3'd4;

  typedef struct packed {
    logic [14:0] monitor_gain;
    logic [14:0] board_gain;
    logic [14:0] duck_gain;
    logic        duck_enable;
    logic        loopback_enable;
  } cfg_t;

  // Classified request between front and back
  typedef struct packed {
    op_e                op;
    logic signed [15:0] sample;
    logic               block_start;
    logic [CW-1:0]      cushion;
  } entry_t;

  typedef struct packed {
    op_e                kind;
    logic signed [15:0] sample;
    logic               overflow;
    logic               underflow;
    logic [14:0]        fill;
  } result_t;

  // Round a Q.29 value to Q1.15 (half up) and saturate
  function automatic logic signed [15:0] round_sat(input logic signed [32:0] v);
    logic signed [32:0] q;
    q = (v + 33'sd8192) >>> 14;
    if (q > 33'sd32767) begin
      return 16'sh7fff;
    end else if (q < -33'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  // Pointer arithmetic modulo twice the ring depth
  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SPAN_W) begin
      s = s - SPAN_W;
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ptr_sub(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      s = s + SPAN_W;
    end
    return s[PW-1:0];
  endfunction

  // Ring slot of a pointer
  function automatic logic [AW-1:0] ptr_idx(input logic [PW-1:0] p);
    logic [PW-1:0] d;
    d = (p >= DEPTH_P) ? (p - DEPTH_P) : p;
    return d[AW-1:0];
  endfunction

endpackage

// ----- hw/rtl/monitor_jitter_buffer_mixer.sv -----
// ----------------------------------------------------------------------------
// monitor_jitter_buffer_mixer
// Headphone monitor mix into a ring with pre-roll, trim and underflow handling.
// ----------------------------------------------------------------------------
// Result path: front stage 1, request queue, back stages 1 and 2, result buffer.
// Throughput: one request per cycle while in_ready_o and out_ready_i stay high,
//   set by the pointer update and one ring access per request in the back part.
// Reset: pointers, pre-roll flags and queues clear, gains return to defaults;
//   ring contents are not cleared and need no clearing pass.
module monitor_jitter_buffer_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic signed [15:0] voice_sample_i,
  input  logic signed [15:0] board_sample_i,
  input  logic               board_active_i,
  input  logic               block_start_i,
  input  logic [12:0]        block_len_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic signed [15:0] monitor_sample_o,
  output logic               overflow_o,
  output logic               underflow_o,
  output logic [14:0]        fill_level_o
);
  import mjb_pkg::*;

  `include "monitor_jitter_buffer_mixer_macros.svh"

  cfg_t            cfg_q;
  logic            q_wr;
  entry_t          q_wdata;
  logic            q_rd;
  logic            q_valid;
  entry_t          q_rdata;
  logic [QCW-1:0]  q_cnt;
  result_t         res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.monitor_gain    <= GAIN_UNITY;
      cfg_q.board_gain      <= GAIN_UNITY;
      cfg_q.duck_gain       <= GAIN_UNITY;
      cfg_q.duck_enable     <= 1'b0;
      cfg_q.loopback_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MONITOR_GAIN: cfg_q.monitor_gain    <= cfg_data_i;
        CFG_BOARD_GAIN:   cfg_q.board_gain      <= cfg_data_i;
        CFG_DUCK_GAIN:    cfg_q.duck_gain       <= cfg_data_i;
        CFG_DUCK_EN:      cfg_q.duck_enable     <= cfg_data_i[0];
        CFG_LOOPBACK_EN:  cfg_q.loopback_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mjb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .voice_sample_i (voice_sample_i),
    .board_sample_i (board_sample_i),
    .board_active_i (board_active_i),
    .block_start_i  (block_start_i),
    .block_len_i    (block_len_i),
    .q_count_i      (q_cnt),
    .q_wr_o         (q_wr),
    .q_data_o       (q_wdata)
  );

  mjb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_data_i  (q_wdata),
    .rd_i       (q_rd),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_rdata),
    .count_o    (q_cnt)
  );

  mjb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_rd_o      (q_rd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (res)
  );

  assign kind_o           = res.kind;
  assign monitor_sample_o = res.sample;
  assign overflow_o       = res.overflow;
  assign underflow_o      = res.underflow;
  assign fill_level_o     = res.fill;

  // Checks
  `MJB_ASSERT_IMP(a_push_no_sample, out_valid_o && (kind_o == OP_PUSH), (monitor_sample_o == 16'sd0) && !underflow_o, "push result carries pull data")
  `MJB_ASSERT_IMP(a_pull_no_ovf, out_valid_o && (kind_o == OP_PULL), !overflow_o, "pull result flags overflow")
  `MJB_ASSERT_IMP(a_unf_silent, out_valid_o && underflow_o, monitor_sample_o == 16'sd0, "underflow result not silent")
  `MJB_ASSERT_NXT(a_queue_bound, q_wr && !q_rd, (q_cnt != '0) && (q_cnt <= QCW'(QDEPTH)), "request queue count out of range")

endmodule

// ----- hw/rtl/mjb_front.sv -----
// ----------------------------------------------------------------------------
// mjb_front
// Accepts requests, forms the push mix and the pull cushion, feeds the queue.
// ----------------------------------------------------------------------------
module mjb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mjb_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic signed [15:0]   voice_sample_i,
  input  logic signed [15:0]   board_sample_i,
  input  logic                 board_active_i,
  input  logic                 block_start_i,
  input  logic [12:0]          block_len_i,
  input  logic [mjb_pkg::QCW-1:0] q_count_i,
  output logic                 q_wr_o,
  output mjb_pkg::entry_t      q_data_o
);
  import mjb_pkg::*;

  logic                 acc;
  logic [14:0]          vgain;
  logic signed [31:0]   pv_d;
  logic signed [31:0]   pb_d;
  logic [14:0]          len3;
  logic [CW-1:0]        cush_d;
  logic                 f1_v_q;
  op_e                  f1_op_q;
  logic                 f1_bs_q;
  logic [CW-1:0]        f1_cush_q;
  logic signed [31:0]   f1_pv_q;
  logic signed [31:0]   f1_pb_q;
  logic signed [32:0]   sum;

  // Credit: queue plus the stage in flight must fit
  assign in_ready_o = ({1'b0, q_count_i} + (QCW + 1)'(f1_v_q)) < (QCW + 1)'(QDEPTH);
  assign acc        = in_valid_i && in_ready_o;

  // Voice gain: ducked, unity, or muted without loopback
  always_comb begin
    if (!cfg_i.loopback_enable) begin
      vgain = '0;
    end else if (cfg_i.duck_enable && board_active_i) begin
      vgain = cfg_i.duck_gain;
    end else begin
      vgain = GAIN_UNITY;
    end
  end

  assign pv_d = voice_sample_i * $signed({1'b0, vgain});
  assign pb_d = board_sample_i * $signed({1'b0, cfg_i.board_gain});

  // Cushion = min(3 * block length, half the ring)
  assign len3   = {2'b00, block_len_i} + {1'b0, block_len_i, 1'b0};
  assign cush_d = (MW'(len3) < MW'(HALF)) ? CW'(len3) : CW'(HALF);

  // Stage 1: products and classification
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else begin
      f1_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      f1_op_q   <= op_e'(opcode_i);
      f1_bs_q   <= block_start_i;
      f1_cush_q <= cush_d;
      f1_pv_q   <= pv_d;
      f1_pb_q   <= pb_d;
    end
  end

  // Sum, round and saturate into the queue
  assign sum = $signed({f1_pv_q[31], f1_pv_q}) + $signed({f1_pb_q[31], f1_pb_q});

  always_comb begin
    q_wr_o               = f1_v_q;
    q_data_o.op          = f1_op_q;
    q_data_o.sample      = round_sat(sum);
    q_data_o.block_start = f1_bs_q;
    q_data_o.cushion     = f1_cush_q;
  end

endmodule

// ----- hw/rtl/mjb_queue.sv -----
// ----------------------------------------------------------------------------
// mjb_queue
// Short request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module mjb_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_i,
  input  mjb_pkg::entry_t         wr_data_i,
  input  logic                    rd_i,
  output logic                    rd_valid_o,
  output mjb_pkg::entry_t         rd_data_o,
  output logic [mjb_pkg::QCW-1:0] count_o
);
  import mjb_pkg::*;

  entry_t          slot_q [QDEPTH];
  logic [QAW-1:0]  wp_q;
  logic [QAW-1:0]  rp_q;
  logic [QCW-1:0]  cnt_q;
  logic [QCW-1:0]  cnt_d;

  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = slot_q[rp_q];
  assign count_o    = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wp_q <= wp_q + QAW'(1);
      end
      if (rd_i) begin
        rp_q <= rp_q + QAW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wp_q] <= wr_data_i;
    end
  end

endmodule

// ----- hw/rtl/mjb_back.sv -----
// ----------------------------------------------------------------------------
// mjb_back
// Ring control, ring memory, monitor gain and the result buffer.
// ----------------------------------------------------------------------------
module mjb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mjb_pkg::cfg_t        cfg_i,
  input  logic                 q_valid_i,
  input  mjb_pkg::entry_t      q_data_i,
  output logic                 q_rd_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mjb_pkg::result_t     out_data_o
);
  import mjb_pkg::*;

  // Ring state
  logic [15:0]      ring_q [RING_DEPTH];
  logic [PW-1:0]    wp_q, wp_d;
  logic [PW-1:0]    rp_q, rp_d;
  logic             primed_q, primed_d;
  logic             silent_q, silent_d;

  // Issue-cycle signals
  logic             pop;
  logic [PW-1:0]    fill;
  logic [PW-1:0]    fill_a;
  logic [PW-1:0]    fill_after;
  logic [PW-1:0]    cush_p;
  logic [PW-1:0]    rp_a;
  logic             primed_a;
  logic             silent_a;
  logic             mem_we;
  logic             mem_re;
  logic             ovf;
  logic             unf;

  // Stage 1: memory read in flight
  logic             b1_v_q;
  op_e              b1_kind_q;
  logic             b1_ovf_q;
  logic             b1_unf_q;
  logic [14:0]      b1_fill_q;
  logic             b1_rd_q;
  logic [15:0]      rdata_q;

  // Stage 2: scaled sample
  logic             b2_v_q;
  op_e              b2_kind_q;
  logic             b2_ovf_q;
  logic             b2_unf_q;
  logic [14:0]      b2_fill_q;
  logic signed [31:0] b2_prod_q;
  logic signed [31:0] prod_d;

  // Result buffer
  result_t          oq_q [OQ_DEPTH];
  logic [OQAW-1:0]  oq_wp_q;
  logic [OQAW-1:0]  oq_rp_q;
  logic [OQCW-1:0]  oq_cnt_q;
  logic             oq_pop;
  result_t          res;

  // Issue only with room for everything in flight
  assign pop = q_valid_i &&
               (({1'b0, oq_cnt_q} + (OQCW + 1)'(b1_v_q) + (OQCW + 1)'(b2_v_q))
                < (OQCW + 1)'(OQ_DEPTH));
  assign q_rd_o = pop;

  assign fill   = ptr_sub(wp_q, rp_q);
  assign cush_p = PW'(q_data_i.cushion);

  // Ring control for one request
  always_comb begin
    wp_d       = wp_q;
    rp_d       = rp_q;
    primed_d   = primed_q;
    silent_d   = silent_q;
    primed_a   = primed_q;
    silent_a   = silent_q;
    rp_a       = rp_q;
    fill_a     = fill;
    fill_after = fill;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    ovf        = 1'b0;
    unf        = 1'b0;
    if (pop) begin
      if (q_data_i.op == OP_PUSH) begin
        if (fill >= DEPTH_P) begin
          ovf = 1'b1;
        end else begin
          mem_we     = 1'b1;
          wp_d       = ptr_add(wp_q, PW'(1));
          fill_after = fill + PW'(1);
        end
      end else begin
        // Block start: set pre-roll and trim backlog
        if (q_data_i.block_start) begin
          silent_a = 1'b0;
          if (!primed_q) begin
            if (fill >= cush_p) begin
              primed_a = 1'b1;
            end else begin
              silent_a = 1'b1;
            end
          end
          if (primed_a && (fill > PW'({q_data_i.cushion, 1'b0}))) begin
            rp_a   = ptr_sub(wp_q, cush_p);
            fill_a = cush_p;
          end
        end
        rp_d       = rp_a;
        fill_after = fill_a;
        primed_d   = primed_a;
        silent_d   = silent_a;
        // Read, or underflow and re-arm
        if (primed_a && !silent_a) begin
          if (fill_a == '0) begin
            unf      = 1'b1;
            primed_d = 1'b0;
            silent_d = 1'b1;
          end else begin
            mem_re     = 1'b1;
            rp_d       = ptr_add(rp_a, PW'(1));
            fill_after = fill_a - PW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      primed_q <= 1'b0;
      silent_q <= 1'b0;
      b1_v_q   <= 1'b0;
      b2_v_q   <= 1'b0;
    end else begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      primed_q <= primed_d;
      silent_q <= silent_d;
      b1_v_q   <= pop;
      b2_v_q   <= b1_v_q;
    end
  end

  // Ring memory: one write or one read per request
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[ptr_idx(wp_q)] <= q_data_i.sample;
    end
    if (mem_re) begin
      rdata_q <= ring_q[ptr_idx(rp_a)];
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      b1_kind_q <= q_data_i.op;
      b1_ovf_q  <= ovf;
      b1_unf_q  <= unf;
      b1_fill_q <= 15'(fill_after);
      b1_rd_q   <= mem_re;
    end
  end

  // Stage 2: monitor gain, signed sample times unsigned gain
  assign prod_d = b1_rd_q ? ($signed(rdata_q) * $signed({1'b0, cfg_i.monitor_gain}))
                          : 32'sd0;

  always_ff @(posedge clk_i) begin
    if (b1_v_q) begin
      b2_kind_q <= b1_kind_q;
      b2_ovf_q  <= b1_ovf_q;
      b2_unf_q  <= b1_unf_q;
      b2_fill_q <= b1_fill_q;
      b2_prod_q <= prod_d;
    end
  end

  // Round into the result buffer
  always_comb begin
    res.kind      = b2_kind_q;
    res.sample    = round_sat($signed({b2_prod_q[31], b2_prod_q}));
    res.overflow  = b2_ovf_q;
    res.underflow = b2_unf_q;
    res.fill      = b2_fill_q;
  end

  assign out_valid_o = (oq_cnt_q != '0);
  assign out_data_o  = oq_q[oq_rp_q];
  assign oq_pop      = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= '0;
      oq_rp_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (b2_v_q) begin
        oq_wp_q <= oq_wp_q + OQAW'(1);
      end
      if (oq_pop) begin
        oq_rp_q <= oq_rp_q + OQAW'(1);
      end
      if (b2_v_q && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + OQCW'(1);
      end else if (oq_pop && !b2_v_q) begin
        oq_cnt_q <= oq_cnt_q - OQCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b2_v_q) begin
      oq_q[oq_wp_q] <= res;
    end
  end

endmodule
